// File: src/pedal_pulse_odometer_unit_assert.svh
// Assertion macros for the pedal pulse odometer.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef PEDAL_PULSE_ODOMETER_UNIT_ASSERT_SVH
`define PEDAL_PULSE_ODOMETER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PPO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define PPO_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPO_ASSERT(lbl, prop, msg)
`define PPO_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: src/ppo_pkg.sv
// Shared types and constants of the pedal pulse odometer.
// No dependencies.
package ppo_pkg;

  localparam int REV_COUNT_BITS = 24;
  localparam int CFG_W          = 8;
  localparam int TICK_W         = 32;
  localparam int REV_OUT_W      = 24;
  localparam int DIST_W         = 29;
  localparam int SEC_W          = 23;
  localparam int SPEED_W        = 20;
  localparam int CFG_IDX_W      = 2;

  localparam int PROD_W     = REV_COUNT_BITS + CFG_W;
  localparam int SPD_PROD_W = DIST_W + 9;
  localparam int DIV_W      = (PROD_W > SPD_PROD_W) ? PROD_W : SPD_PROD_W;
  localparam int REM_W      = SEC_W + 1;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);

  localparam logic [SEC_W-1:0]   DIST_DIV    = SEC_W'(10);
  localparam logic [SEC_W-1:0]   MS_PER_S    = SEC_W'(1000);
  localparam logic [8:0]         SPEED_SCALE = 9'd360;
  localparam logic [DIST_W-1:0]  DIST_MAX    = {DIST_W{1'b1}};
  localparam logic [SPEED_W-1:0] SPEED_MAX   = {SPEED_W{1'b1}};
  localparam logic [REV_COUNT_BITS-1:0] REV_MAX = {REV_COUNT_BITS{1'b1}};

  localparam logic [CFG_W-1:0] RST_THRESHOLD = 8'd10;
  localparam logic [CFG_W-1:0] RST_DPR       = 8'd53;
  localparam logic             RST_IDLE_LVL  = 1'b0;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DPR       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_IDLE_LVL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST_GO,
    ST_DIST_WAIT,
    ST_SEC_WAIT,
    ST_SPD_WAIT,
    ST_DONE
  } ppo_state_t;

  typedef struct packed {
    logic              counted;
    logic [TICK_W-1:0] tick_ms;
  } dbn_status_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [SEC_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: src/ppo_debounce.sv
// Integrating debounce, low-seen tracking and millisecond counter.
// Depends on ppo_pkg.
module ppo_debounce (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        tick,
  input  logic                        level,
  input  logic [ppo_pkg::CFG_W-1:0]   threshold,
  input  logic                        idle_level,
  output ppo_pkg::dbn_status_t        status
);
  import ppo_pkg::*;

  logic [TICK_W-1:0] tick_ms_r, tick_ms_nxt;
  logic [7:0]        integ_r, integ_nxt, integ_step;
  logic              low_seen_r, low_seen_nxt, low_step;
  logic              qualify, counted;

  always_comb begin
    low_step = (level == 1'b0) ? 1'b1 : low_seen_r;
    integ_step = integ_r;
    if (level == idle_level) begin
      if (integ_r != 8'd0) integ_step = integ_r - 8'd1;
    end else if (integ_r != 8'hFF) begin
      integ_step = integ_r + 8'd1;
    end
    qualify      = (integ_step >= threshold);
    counted      = qualify && level && low_step;
    integ_nxt    = qualify ? 8'd0 : integ_step;
    low_seen_nxt = counted ? 1'b0 : low_step;
    tick_ms_nxt  = tick_ms_r + TICK_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_ms_r  <= '0;
      integ_r    <= '0;
      low_seen_r <= 1'b0;
    end else if (tick) begin
      tick_ms_r  <= tick_ms_nxt;
      integ_r    <= integ_nxt;
      low_seen_r <= low_seen_nxt;
    end
  end

  assign status.counted = counted;
  assign status.tick_ms = tick_ms_r;

endmodule

// File: src/ppo_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on ppo_pkg.
module ppo_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppo_pkg::div_req_t    req,
  output ppo_pkg::div_rsp_t    rsp
);
  import ppo_pkg::*;

  logic [DIV_CNT_W-1:0] count_r;
  logic                 done_r;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt, rem_sh, div_ext;
  logic [SEC_W-1:0]     div_r;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem_r[REM_W-2:0], quo_r[DIV_W-1]};
    div_ext = {1'b0, div_r};
    ge      = (rem_sh >= div_ext);
    rem_nxt = ge ? (rem_sh - div_ext) : rem_sh;
    quo_nxt = {quo_r[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        count_r <= DIV_CNT_W'(DIV_W);
      end else if (count_r != '0) begin
        count_r <= count_r - DIV_CNT_W'(1);
        done_r  <= (count_r == DIV_CNT_W'(1));
      end
    end
  end

  // Operand and partial remainder; shift the quotient in behind the dividend.
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (count_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy     = (count_r != '0);
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// File: src/pedal_pulse_odometer_unit.sv
// Top level of the pedal pulse odometer: handshakes, configuration, sequencer.
// Depends on ppo_pkg, ppo_debounce, ppo_divider and the assertion header.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-------------------------------
//   in_     | input     | in_valid / in_stall   | in_pin_level
//   out_    | output    | out_valid / out_stall | pulse flag, count, distance,
//           |           |                       | seconds, speed and flags
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_wdata
//
// A tick without a counted revolution goes from its input beat straight to DONE
// and its result beat. A counted tick makes up to three 38-step passes through
// the one shared restoring divider (distance / 10, ms / 1000, speed); the speed
// pass is skipped while the elapsed seconds are still zero.
// in_stall is high from an accepted beat until its result sits in the output
// register; the next beat is taken while that result still waits on out_stall.
// Reset (rst_n low at a clock edge) clears all counters and held values and sets
// the configuration registers to their defaults; the output payload registers are not reset; cfg_ready is always high.
`include "pedal_pulse_odometer_unit_assert.svh"
module pedal_pulse_odometer_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_pin_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_pulse_counted,
  output logic [ppo_pkg::REV_OUT_W-1:0]     out_revolutions,
  output logic [ppo_pkg::DIST_W-1:0]        out_distance_m,
  output logic [ppo_pkg::SEC_W-1:0]         out_elapsed_s,
  output logic [ppo_pkg::SPEED_W-1:0]       out_avg_speed_centi_kmh,
  output logic                              out_speed_invalid,
  output logic                              out_speed_saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppo_pkg::CFG_W-1:0]         cfg_wdata
);
  import ppo_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] threshold_r;
  logic [CFG_W-1:0] dpr_r;
  logic             idle_lvl_r;

  // Sequencer and held results of the last count
  ppo_state_t                state_r, state_nxt;
  logic                      counted_r;
  logic [REV_COUNT_BITS-1:0] rev_count_r;
  logic [DIST_W-1:0]         distance_r;
  logic [SEC_W-1:0]          seconds_r;
  logic [SPEED_W-1:0]        speed_r;
  logic                      invalid_r;
  logic                      saturated_r;
  logic                      out_valid_r;

  logic                      in_accept;
  logic                      out_free;
  dbn_status_t               dbn_status;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  logic [PROD_W-1:0]         dist_prod;
  logic [SPD_PROD_W-1:0]     speed_prod;
  logic                      sec_zero;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= RST_THRESHOLD;
      dpr_r       <= RST_DPR;
      idle_lvl_r  <= RST_IDLE_LVL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_THRESHOLD: threshold_r <= cfg_wdata;
        CFG_IDX_DPR:       dpr_r       <= cfg_wdata;
        CFG_IDX_IDLE_LVL:  idle_lvl_r  <= cfg_wdata[0];
        default:           ; // drop writes past the register list
      endcase
    end
  end

  ppo_debounce u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick       (in_accept),
    .level      (in_pin_level),
    .threshold  (threshold_r),
    .idle_level (idle_lvl_r),
    .status     (dbn_status)
  );

  ppo_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Operand products feed the divider's dividend register directly.
  assign dist_prod  = PROD_W'(rev_count_r) * PROD_W'(dpr_r);
  assign speed_prod = SPD_PROD_W'(distance_r) * SPD_PROD_W'(SPEED_SCALE);
  assign sec_zero   = (div_rsp.quotient == '0);

  // Next state and divider requests
  always_comb begin
    state_nxt        = state_r;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(dist_prod);
    div_req.divisor  = DIST_DIV;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = dbn_status.counted ? ST_DIST_GO : ST_DONE;
      end
      ST_DIST_GO: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DIST_WAIT;
      end
      ST_DIST_WAIT: begin
        if (div_rsp.done) begin
          // Start ms / 1000 as soon as the distance is out.
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(dbn_status.tick_ms);
          div_req.divisor  = MS_PER_S;
          state_nxt        = ST_SEC_WAIT;
        end
      end
      ST_SEC_WAIT: begin
        if (div_rsp.done) begin
          if (sec_zero) begin
            state_nxt = ST_DONE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(speed_prod);
            div_req.divisor  = div_rsp.quotient[SEC_W-1:0];
            state_nxt        = ST_SPD_WAIT;
          end
        end
      end
      ST_SPD_WAIT: begin
        if (div_rsp.done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Revolution count and values held from the last count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counted_r   <= 1'b0;
      rev_count_r <= '0;
      distance_r  <= '0;
      seconds_r   <= '0;
      speed_r     <= '0;
      invalid_r   <= 1'b0;
      saturated_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            counted_r <= dbn_status.counted;
            // Saturate the count; a qualified pulse still recomputes.
            if (dbn_status.counted && rev_count_r != REV_MAX)
              rev_count_r <= rev_count_r + REV_COUNT_BITS'(1);
          end
        end
        ST_DIST_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient > DIV_W'(DIST_MAX)) distance_r <= DIST_MAX;
            else distance_r <= div_rsp.quotient[DIST_W-1:0];
          end
        end
        ST_SEC_WAIT: begin
          if (div_rsp.done) begin
            seconds_r <= div_rsp.quotient[SEC_W-1:0];
            if (sec_zero) begin
              speed_r     <= '0;
              invalid_r   <= 1'b1;
              saturated_r <= 1'b0;
            end
          end
        end
        ST_SPD_WAIT: begin
          if (div_rsp.done) begin
            invalid_r <= 1'b0;
            if (div_rsp.quotient > DIV_W'(SPEED_MAX)) begin
              speed_r     <= SPEED_MAX;
              saturated_r <= 1'b1;
            end else begin
              speed_r     <= div_rsp.quotient[SPEED_W-1:0];
              saturated_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: load in DONE once the previous beat has left.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_pulse_counted       <= counted_r;
      out_revolutions         <= REV_OUT_W'(rev_count_r);
      out_distance_m          <= distance_r;
      out_elapsed_s           <= seconds_r;
      out_avg_speed_centi_kmh <= speed_r;
      out_speed_invalid       <= invalid_r;
      out_speed_saturated     <= saturated_r;
    end
  end

  `PPO_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_r, "out_valid after reset")
  `PPO_ASSERT(a_skip_to_done, (in_accept && !dbn_status.counted) |=> state_r == ST_DONE, "no-count beat did not skip the divider")
  `PPO_ASSERT(a_out_from_done, $rose(out_valid_r) |-> $past(state_r) == ST_DONE, "result loaded outside DONE")
  `PPO_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider restarted while busy")
  `PPO_ASSERT(a_flags_exclusive, out_valid_r |-> !(out_speed_invalid && out_speed_saturated), "both speed flags set")

endmodule
